// File: hdl/rgbgt_pkg.sv
// shared types, constants and expansion tables for the rgb565 grayscale tint pipeline
`default_nettype none

package rgbgt_pkg;

    // luma weights and divisor
    localparam int LUMA_WR  = 30;
    localparam int LUMA_WG  = 59;
    localparam int LUMA_WB  = 11;
    localparam int LUMA_DIV = 100;

    // full scale of an 8-bit channel and the 5/6-bit channel maxima
    localparam int FULL8   = 255;
    localparam int CH5_MAX = 31;
    localparam int CH6_MAX = 63;

    // x / 100 == (x * 5243) >> 19 for every weighted sum up to 25500
    localparam int DIV100_RECIP = 5243;
    localparam int DIV100_SHIFT = 19;

    localparam int SUM_W   = 15;
    localparam int GAIN_W  = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // register indexes on the configuration channel
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET = 2'd0,
        CFG_GAIN   = 2'd1,
        CFG_SWAP   = 2'd2
    } t_cfg_idx;

    typedef logic [31:0][7:0] t_tab5;
    typedef logic [63:0][7:0] t_tab6;

    function automatic t_tab5 f_tab5();
        t_tab5 tab;
        for (int i = 0; i < 32; i++) begin
            tab[i] = 8'((i * FULL8) / CH5_MAX);
        end
        return tab;
    endfunction

    function automatic t_tab6 f_tab6();
        t_tab6 tab;
        for (int i = 0; i < 64; i++) begin
            tab[i] = 8'((i * FULL8) / CH6_MAX);
        end
        return tab;
    endfunction

    // c * 255 / 31 and c * 255 / 63, truncated
    localparam t_tab5 EXP5 = f_tab5();
    localparam t_tab6 EXP6 = f_tab6();

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb8;

    typedef struct packed {
        t_rgb8 rgb;
        logic  last;
    } t_chan_beat;

    typedef struct packed {
        logic [7:0] scaled;
        logic       last;
    } t_luma_beat;

    typedef struct packed {
        t_rgb8 target;
        logic  swap;
    } t_tint_cfg;

endpackage

`default_nettype wire

// File: hdl/rgb565_grayscale_tint.sv
// top level of the rgb565 grayscale tint pipeline with its configuration registers
`default_nettype none

// Colorizes an RGB565 pixel stream: each byte-swapped source pixel is reduced to a
// luma, scaled by an unsigned Q4.8 gain (clamped to 255) and used to shade the
// configured target color; the result is repacked to RGB565 and optionally byte
// swapped. The pipeline accepts one pixel per clock while the output is not stalled
// and holds six register stages (expand, weighted sum, divide by 100, gain, tint
// multiply, divide by 255 and pack). Each stage has its own valid bit, so bubbles
// are squeezed out under backpressure. Configuration writes are always taken
// (index 0 target color, 1 brightness gain, 2 output swap; index 3 is ignored) and
// must be done while no pixel is in flight; the expanded target color is held in
// its own register behind the target register.
module rgb565_grayscale_tint
    import rgbgt_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration write channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data,
    // pixel input stream
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  wire logic [15:0]          i_s_axis_tdata,  // [15:0] pixel_in
    input  wire logic                 i_s_axis_tlast,
    // pixel output stream
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    output logic [15:0]               o_m_axis_tdata,  // [15:0] pixel_out
    output logic                      o_m_axis_tlast
);

    logic [15:0]       r_target;
    logic [GAIN_W-1:0] r_gain;
    logic              r_swap;
    t_rgb8             r_target8;
    t_tint_cfg         w_tint_cfg;
    logic              w_cfg_wr;

    logic       w_exp_valid, w_exp_ready;
    t_chan_beat w_exp_beat;
    logic       w_luma_valid, w_luma_ready;
    t_luma_beat w_luma_beat;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= 16'hFFFF;
            r_gain   <= GAIN_W'(256);
            r_swap   <= 1'b0;
        end else if (w_cfg_wr) begin
            case (i_cfg_index)
                CFG_TARGET: r_target <= i_cfg_data;
                CFG_GAIN:   r_gain   <= i_cfg_data[GAIN_W-1:0];
                CFG_SWAP:   r_swap   <= i_cfg_data[0];
                default:    ;
            endcase
        end
    end

    // target color static while pixels flow is user's task; expand once per cycle
    always_ff @(posedge i_clk) begin
        r_target8.r <= EXP5[r_target[15:11]];
        r_target8.g <= EXP6[r_target[10:5]];
        r_target8.b <= EXP5[r_target[4:0]];
    end

    assign w_tint_cfg.target = r_target8;
    assign w_tint_cfg.swap   = r_swap;

    rgbgt_expand u_expand (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_pixel (i_s_axis_tdata),
        .i_last  (i_s_axis_tlast),
        .o_valid (w_exp_valid),
        .i_ready (w_exp_ready),
        .o_beat  (w_exp_beat)
    );

    rgbgt_luma u_luma (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_gain  (r_gain),
        .i_valid (w_exp_valid),
        .o_ready (w_exp_ready),
        .i_beat  (w_exp_beat),
        .o_valid (w_luma_valid),
        .i_ready (w_luma_ready),
        .o_beat  (w_luma_beat)
    );

    rgbgt_tint u_tint (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_tint_cfg),
        .i_valid (w_luma_valid),
        .o_ready (w_luma_ready),
        .i_beat  (w_luma_beat),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_pixel (o_m_axis_tdata),
        .o_last  (o_m_axis_tlast)
    );

    // input side only backs up when the output holds a result that is not taken
    a_stall_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input stalled while output is free");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    a_gain_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cfg_wr && i_cfg_index == CFG_GAIN) |=> r_gain == $past(i_cfg_data[GAIN_W-1:0]))
        else $error("gain register did not take the write");

    a_target_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cfg_wr && i_cfg_index == CFG_TARGET) |=> r_target == $past(i_cfg_data))
        else $error("target color register did not take the write");

endmodule

`default_nettype wire

// File: hdl/rgbgt_expand.sv
// stage one: byte swap of the source pixel and expansion to 8-bit channels
`default_nettype none

module rgbgt_expand
    import rgbgt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [15:0] i_pixel,
    input  wire logic        i_last,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_chan_beat       o_beat
);

    logic        r_vld;
    t_chan_beat  r_beat;
    logic [15:0] w_px;

    assign w_px    = {i_pixel[7:0], i_pixel[15:8]};
    assign o_ready = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat.rgb.r <= EXP5[w_px[15:11]];
            r_beat.rgb.g <= EXP6[w_px[10:5]];
            r_beat.rgb.b <= EXP5[w_px[4:0]];
            r_beat.last  <= i_last;
        end
    end

    assign o_valid = r_vld;
    assign o_beat  = r_beat;

endmodule

`default_nettype wire

// File: hdl/rgbgt_luma.sv
// stages two to four: weighted sum, divide by 100, gain and clamp
`default_nettype none

module rgbgt_luma
    import rgbgt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [GAIN_W-1:0] i_gain,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire t_chan_beat        i_beat,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output t_luma_beat             o_beat
);

    localparam int QUO_W  = SUM_W + 13;
    localparam int PROD_W = 8 + GAIN_W;

    logic             r_vld1, r_vld2, r_vld3;
    logic             w_rdy1, w_rdy2, w_rdy3;
    logic [SUM_W-1:0] r_sum;
    logic             r_last1, r_last2;
    logic [7:0]       r_luma;
    t_luma_beat       r_beat;
    logic [QUO_W-1:0] w_quo;
    logic [PROD_W-1:0] w_prod;

    assign w_rdy3  = !r_vld3 || i_ready;
    assign w_rdy2  = !r_vld2 || w_rdy3;
    assign w_rdy1  = !r_vld1 || w_rdy2;
    assign o_ready = w_rdy1;

    assign w_quo  = QUO_W'(r_sum) * QUO_W'(DIV100_RECIP);
    assign w_prod = PROD_W'(r_luma) * PROD_W'(i_gain);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_vld1 <= i_valid;
            end
            if (w_rdy2) begin
                r_vld2 <= r_vld1;
            end
            if (w_rdy3) begin
                r_vld3 <= r_vld2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_sum   <= SUM_W'(LUMA_WR * int'(i_beat.rgb.r) + LUMA_WG * int'(i_beat.rgb.g)
                              + LUMA_WB * int'(i_beat.rgb.b));
            r_last1 <= i_beat.last;
        end
        if (w_rdy2 && r_vld1) begin
            r_luma  <= w_quo[DIV100_SHIFT +: 8];
            r_last2 <= r_last1;
        end
        if (w_rdy3 && r_vld2) begin
            // drop the 8 fraction bits, saturate at full scale
            if (|w_prod[PROD_W-1:16]) begin
                r_beat.scaled <= 8'(FULL8);
            end else begin
                r_beat.scaled <= w_prod[15:8];
            end
            r_beat.last <= r_last2;
        end
    end

    assign o_valid = r_vld3;
    assign o_beat  = r_beat;

endmodule

`default_nettype wire

// File: hdl/rgbgt_tint.sv
// stages five and six: tint multiply, divide by 255, repack to rgb565 and swap
`default_nettype none

module rgbgt_tint
    import rgbgt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_tint_cfg   i_cfg,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire t_luma_beat  i_beat,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [15:0]      o_pixel,
    output logic             o_last
);

    logic        r_vld1, r_vld2;
    logic        w_rdy1, w_rdy2;
    logic [15:0] r_pr, r_pg, r_pb;
    logic        r_last1;
    logic [15:0] r_pixel;
    logic        r_last;
    logic [16:0] w_qr, w_qg, w_qb;
    logic [15:0] w_res;

    assign w_rdy2  = !r_vld2 || i_ready;
    assign w_rdy1  = !r_vld1 || w_rdy2;
    assign o_ready = w_rdy1;

    // x / 255 == (x + (x >> 8) + 1) >> 8 for x below 65535
    assign w_qr = 17'(r_pr) + 17'(r_pr[15:8]) + 17'd1;
    assign w_qg = 17'(r_pg) + 17'(r_pg[15:8]) + 17'd1;
    assign w_qb = 17'(r_pb) + 17'(r_pb[15:8]) + 17'd1;

    assign w_res = {w_qr[15:11], w_qg[15:10], w_qb[15:11]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_vld1 <= i_valid;
            end
            if (w_rdy2) begin
                r_vld2 <= r_vld1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_pr    <= 16'(i_cfg.target.r) * 16'(i_beat.scaled);
            r_pg    <= 16'(i_cfg.target.g) * 16'(i_beat.scaled);
            r_pb    <= 16'(i_cfg.target.b) * 16'(i_beat.scaled);
            r_last1 <= i_beat.last;
        end
        if (w_rdy2 && r_vld1) begin
            if (i_cfg.swap) begin
                r_pixel <= {w_res[7:0], w_res[15:8]};
            end else begin
                r_pixel <= w_res;
            end
            r_last <= r_last1;
        end
    end

    assign o_valid = r_vld2;
    assign o_pixel = r_pixel;
    assign o_last  = r_last;

endmodule

`default_nettype wire
